// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RNG block's RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/clsr_pkg.sv =====
// Types, constants and controller/datapath command structs for the combined LCG RNG.
// Used by clsr_cdiv, clsr_ctrl, clsr_dpath and combined_lcg_shuffle_rng; no dependencies.
package clsr_pkg;

  localparam int unsigned TableSize = 32;
  localparam int unsigned SlotW     = $clog2(TableSize);
  localparam int unsigned WarmSteps = TableSize + 8;
  localparam int unsigned WarmW     = $clog2(WarmSteps);

  localparam logic [30:0] ModOne  = 31'd2147483563;
  localparam logic [30:0] ModTwo  = 31'd2147483399;
  localparam logic [15:0] MulOne  = 16'd40014;
  localparam logic [15:0] MulTwo  = 16'd40692;
  // 2^31 mod each modulus, used to fold high bits back down
  localparam logic [7:0]  FoldOne = 8'(32'h8000_0000 - 32'(ModOne));
  localparam logic [7:0]  FoldTwo = 8'(32'h8000_0000 - 32'(ModTwo));
  localparam int unsigned TopVal  = 32'(ModOne) - 32'd1;
  localparam int unsigned SlotDiv = 1 + TopVal / TableSize;
  localparam logic [30:0] SeedReset = 31'd1;

  localparam int unsigned DivNumW = 63;

  localparam logic CmdReseed = 1'b0;
  localparam logic CmdDraw   = 1'b1;

  typedef logic [30:0] val_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
  } rng_in_t;

  typedef struct packed {
    logic [30:0]        raw_value;
    logic [31:0]        fraction;
    logic signed [31:0] mapped_value;
    logic               bad_range;
    logic               not_seeded;
  } rng_out_t;

  typedef struct packed {
    logic             accept;
    logic             seed_load;
    logic             mul_en;
    logic             tbl_re;
    logic             fold_en;
    logic             gen1_we;
    logic             gen2_we;
    logic             tbl_we;
    logic             tbl_fill;
    logic [SlotW-1:0] fill_idx;
    logic             last_load;
    logic             raw_en;
    logic             div_start;
    logic             div_map;
    logic             span_mul;
    logic             frac_en;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic seeded;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== sv/clsr_cdiv.sv =====
// Iterative divider by the constant modulus 2^31 - FoldOne, one fold step per cycle.
// Depends on clsr_pkg.
module clsr_cdiv (
  input  logic                         clk_i,
  input  logic                         start_i,
  input  logic [clsr_pkg::DivNumW-1:0] num_i,
  output logic [31:0]                  quot_o,
  output logic                         done_o
);

  logic [clsr_pkg::DivNumW-1:0] rem_q, rem_d;
  logic [31:0]                  quot_q, quot_d;
  logic [31:0]                  hi;

  assign hi = rem_q[62:31];

  // hi * 2^31 equals hi * mod + hi * FoldOne: move hi into the quotient
  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      rem_d  = num_i;
      quot_d = '0;
    end else if (hi != '0) begin
      rem_d  = 63'(rem_q[30:0]) + 63'(hi) * 63'(clsr_pkg::FoldOne);
      quot_d = quot_q + hi;
    end else if (rem_q[30:0] >= clsr_pkg::ModOne) begin
      rem_d  = 63'(rem_q[30:0] - clsr_pkg::ModOne);
      quot_d = quot_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = (hi == '0) && (rem_q[30:0] < clsr_pkg::ModOne);
  assign quot_o = quot_q;

endmodule

// ===== sv/clsr_ctrl.sv =====
// Sequencer for reseed and draw transactions; drives the datapath command struct.
// Depends on clsr_pkg.
module clsr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  clsr_pkg::dp_stat_t stat_i,
  output clsr_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SMul     = 4'd1;
  localparam logic [3:0] SFold    = 4'd2;
  localparam logic [3:0] SRed     = 4'd3;
  localparam logic [3:0] SRaw     = 4'd4;
  localparam logic [3:0] SFracLd  = 4'd5;
  localparam logic [3:0] SFracDiv = 4'd6;
  localparam logic [3:0] SMapDiv  = 4'd7;
  localparam logic [3:0] SOut     = 4'd8;

  logic [3:0]                 state_q, state_d;
  logic [clsr_pkg::WarmW-1:0] cnt_q, cnt_d;
  logic                       draw_q, draw_d;
  logic                       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    draw_d      = draw_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_cmd_i == clsr_pkg::CmdReseed) begin
            cmd_o.seed_load = 1'b1;
            cnt_d   = clsr_pkg::WarmW'(clsr_pkg::WarmSteps - 1);
            draw_d  = 1'b0;
            state_d = SMul;
          end else if (stat_i.seeded) begin
            draw_d  = 1'b1;
            state_d = SMul;
          end else begin
            state_d = SOut;
          end
        end
      end
      SMul: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.tbl_re = draw_q;
        state_d      = SFold;
      end
      SFold: begin
        cmd_o.fold_en = 1'b1;
        state_d       = SRed;
      end
      SRed: begin
        cmd_o.gen1_we = 1'b1;
        if (draw_q) begin
          cmd_o.gen2_we = 1'b1;
          cmd_o.tbl_we  = 1'b1;
          state_d       = SRaw;
        end else begin
          // warm-up: only the last TableSize steps land in the table
          cmd_o.tbl_we   = cnt_q < clsr_pkg::WarmW'(clsr_pkg::TableSize);
          cmd_o.tbl_fill = 1'b1;
          cmd_o.fill_idx = cnt_q[clsr_pkg::SlotW-1:0];
          if (cnt_q == '0) begin
            cmd_o.last_load = 1'b1;
            state_d         = SIdle;
          end else begin
            cnt_d   = cnt_q - clsr_pkg::WarmW'(1);
            state_d = SMul;
          end
        end
      end
      SRaw: begin
        cmd_o.raw_en = 1'b1;
        state_d      = SFracLd;
      end
      SFracLd: begin
        cmd_o.div_start = 1'b1;
        cmd_o.span_mul  = 1'b1;
        state_d         = SFracDiv;
      end
      SFracDiv: begin
        if (stat_i.div_done) begin
          cmd_o.frac_en   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_map   = 1'b1;
          state_d         = SMapDiv;
        end
      end
      SMapDiv: begin
        if (stat_i.div_done) begin
          state_d = SOut;
        end
      end
      SOut: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      draw_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      draw_q      <= draw_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/clsr_dpath.sv =====
// Datapath: seed register, both LCGs, shuffle table memory, range mapping, output register.
// Depends on clsr_pkg and clsr_cdiv.
module clsr_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [30:0]       cfg_data_i,
  input  clsr_pkg::rng_in_t in_item_i,
  input  clsr_pkg::dp_cmd_t cmd_i,
  output clsr_pkg::dp_stat_t stat_o,
  output clsr_pkg::rng_out_t out_item_o
);

  // slot = last / SlotDiv, saturated to the top entry
  function automatic logic [clsr_pkg::SlotW-1:0] slot_of(input clsr_pkg::val_t v);
    logic [clsr_pkg::SlotW-1:0] s;
    s = '0;
    for (int k = 1; k < clsr_pkg::TableSize; k++) begin
      if ({1'b0, v} >= 32'(k * clsr_pkg::SlotDiv)) begin
        s = clsr_pkg::SlotW'(k);
      end
    end
    return s;
  endfunction

  // f is already folded below 2^31 + 2^24: one more fold or one subtract finishes it
  function automatic clsr_pkg::val_t lcg_reduce(input logic [31:0] f,
                                                input clsr_pkg::val_t m,
                                                input logic [7:0] c);
    clsr_pkg::val_t r;
    if (f[31]) begin
      r = f[30:0] + 31'(c);
    end else if (f[30:0] >= m) begin
      r = f[30:0] - m;
    end else begin
      r = f[30:0];
    end
    return r;
  endfunction

  clsr_pkg::val_t     seed_q, gen1_q, gen2_q, last_q;
  logic               seeded_q, ns_q;
  logic signed [31:0] lo_q, hi_q;
  logic [46:0]        prod1_q, prod2_q;
  logic [31:0]        fold1_q, fold2_q;
  clsr_pkg::val_t     rd_q, raw_q;
  logic [32:0]        span_q;
  logic               bad_q;
  logic [62:0]        mulprod_q;
  logic [31:0]        frac_q;
  clsr_pkg::rng_out_t out_q;

  clsr_pkg::val_t             tbl_mem [clsr_pkg::TableSize];
  logic [clsr_pkg::SlotW-1:0] slot, waddr;
  clsr_pkg::val_t             seed_eff, red1, red2, raw_d;
  logic [31:0]                diff, diff_wrap;
  logic [31:0]                fold1_d, fold2_d;
  logic [32:0]                span_d;
  logic [62:0]                mulprod_d, div_num;
  logic [31:0]                div_quot;
  logic                       div_done;
  clsr_pkg::rng_out_t         out_d;

  assign seed_eff = (seed_q == '0) ? clsr_pkg::val_t'(1) : seed_q;
  assign slot     = slot_of(last_q);
  assign waddr    = cmd_i.tbl_fill ? cmd_i.fill_idx : slot;

  assign fold1_d = 32'(prod1_q[30:0]) + 32'(prod1_q[46:31]) * 32'(clsr_pkg::FoldOne);
  assign fold2_d = 32'(prod2_q[30:0]) + 32'(prod2_q[46:31]) * 32'(clsr_pkg::FoldTwo);
  assign red1    = lcg_reduce(fold1_q, clsr_pkg::ModOne, clsr_pkg::FoldOne);
  assign red2    = lcg_reduce(fold2_q, clsr_pkg::ModTwo, clsr_pkg::FoldTwo);

  assign diff      = {1'b0, rd_q} - {1'b0, gen2_q};
  assign diff_wrap = {1'b0, rd_q} - {1'b0, gen2_q} + 32'(clsr_pkg::TopVal);
  assign raw_d     = (diff[31] || diff == '0) ? diff_wrap[30:0] : diff[30:0];

  assign span_d    = {hi_q[31], hi_q} - {lo_q[31], lo_q} + 33'd1;
  assign mulprod_d = 63'(span_q[31:0]) * 63'(raw_q);

  // a span of 2^32 multiplies by a shift
  assign div_num = (cmd_i.div_map && !span_q[32]) ? mulprod_q : {raw_q, 32'b0};

  clsr_cdiv u_cdiv (
    .clk_i   (clk_i),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  always_comb begin
    out_d.raw_value    = raw_q;
    out_d.fraction     = frac_q;
    out_d.mapped_value = bad_q ? lo_q : lo_q + div_quot;
    out_d.bad_range    = bad_q;
    out_d.not_seeded   = 1'b0;
    if (ns_q) begin
      out_d            = '0;
      out_d.not_seeded = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= clsr_pkg::SeedReset;
      gen1_q   <= '0;
      gen2_q   <= '0;
      last_q   <= '0;
      seeded_q <= 1'b0;
      ns_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        ns_q <= !seeded_q;
      end
      if (cmd_i.seed_load) begin
        gen1_q <= seed_eff;
        gen2_q <= seed_eff;
      end else begin
        if (cmd_i.gen1_we) begin
          gen1_q <= red1;
        end
        if (cmd_i.gen2_we) begin
          gen2_q <= red2;
        end
      end
      if (cmd_i.last_load) begin
        last_q   <= red1;
        seeded_q <= 1'b1;
      end else if (cmd_i.raw_en) begin
        last_q <= raw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lo_q <= in_item_i.low_bound;
      hi_q <= in_item_i.high_bound;
    end
    if (cmd_i.mul_en) begin
      prod1_q <= 47'(gen1_q) * 47'(clsr_pkg::MulOne);
      prod2_q <= 47'(gen2_q) * 47'(clsr_pkg::MulTwo);
    end
    if (cmd_i.fold_en) begin
      fold1_q <= fold1_d;
      fold2_q <= fold2_d;
    end
    if (cmd_i.raw_en) begin
      raw_q  <= raw_d;
      span_q <= span_d;
      bad_q  <= hi_q < lo_q;
    end
    if (cmd_i.span_mul) begin
      mulprod_q <= mulprod_d;
    end
    if (cmd_i.frac_en) begin
      frac_q <= div_quot;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  // shuffle table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_we) begin
      tbl_mem[waddr] <= red1;
    end
    if (cmd_i.tbl_re) begin
      rd_q <= tbl_mem[slot];
    end
  end

  assign stat_o.seeded   = seeded_q;
  assign stat_o.div_done = div_done;
  assign out_item_o      = out_q;

endmodule

// ===== sv/combined_lcg_shuffle_rng.sv =====
// Top level of the combined two-LCG random number generator with a shuffle table.
// Depends on clsr_pkg, clsr_ctrl, clsr_dpath (and clsr_cdiv) and assert_macros.svh.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------
//  cfg      | in        | cfg_valid / ready   | cfg_data_i: seed (31 bits)
//  in       | in        | in_valid / stall    | in_item_i: cmd, low/high bound
//  out      | out       | out_valid / stall   | out_item_o: raw, fraction, mapped, flags
//
// A draw runs from acceptance through SMul, SFold and SRed (generator multiply, fold,
// reduce and table access), then SRaw and SFracLd, then two passes of the shared
// constant divider (SFracDiv, SMapDiv) and the output state SOut before the next acceptance.
// A reseed runs 40 warm-up steps through the LCG multiply-fold-reduce loop
// (SMul, SFold, SRed). A draw before any reseed goes straight from SIdle to SOut.
// Reset clears the generators and the seeded flag; the seed register resets to 1.
// A stalled output holds its transaction; one more input is taken and parks in OUT.
`include "assert_macros.svh"

module combined_lcg_shuffle_rng (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  clsr_pkg::rng_in_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output clsr_pkg::rng_out_t out_item_o
);

  clsr_pkg::dp_cmd_t  cmd;
  clsr_pkg::dp_stat_t stat;
  logic               cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  clsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_item_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  clsr_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

  `ASSERT_IMPLIES(a_draw_wr_seeded, cmd.tbl_we && !cmd.tbl_fill, stat.seeded, "table written by a draw before seeding")
  `ASSERT_IMPLIES(a_accept_quiet, in_valid_i && !in_stall_o, !cmd.out_load && !cmd.div_start, "input taken while a transaction is in flight")
  `ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_o, "output register loaded but not valid")
  `ASSERT_IMPLIES(a_raw_range, out_valid_o && !out_item_o.not_seeded, out_item_o.raw_value != '0 && out_item_o.raw_value < clsr_pkg::ModOne, "raw value out of range")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for combined_lcg_shuffle_rng: seed writes, reseeds and draws.
// Depends on clsr_pkg for payload types and constants; predicts every draw in place.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 140;
  localparam int unsigned HoldCycles   = 600;
  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned PhaseItems   = 150;
  localparam int unsigned PhaseCount   = 10;

  localparam logic [31:0] MinS = 32'h8000_0000;
  localparam logic [31:0] MaxS = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {RowPredict, RowUnseeded, RowBadRange, RowPoint} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        cmd;
    logic [31:0] lo;
    logic [31:0] hi;
  } row_t;

  localparam row_t DirectedRows [17] = '{
    '{RowUnseeded, clsr_pkg::CmdDraw,   32'hFFFF_FFFB, 32'd5},
    '{RowUnseeded, clsr_pkg::CmdDraw,   MaxS,          MinS},
    '{RowPredict,  clsr_pkg::CmdReseed, 32'd0,         32'd0},
    '{RowPoint,    clsr_pkg::CmdDraw,   32'd0,         32'd0},
    '{RowPredict,  clsr_pkg::CmdDraw,   MinS,          MaxS},
    '{RowBadRange, clsr_pkg::CmdDraw,   MaxS,          MinS},
    '{RowPoint,    clsr_pkg::CmdDraw,   MinS,          MinS},
    '{RowPoint,    clsr_pkg::CmdDraw,   MaxS,          MaxS},
    '{RowPredict,  clsr_pkg::CmdDraw,   32'hFFFF_FFFF, 32'd0},
    '{RowPredict,  clsr_pkg::CmdDraw,   32'd0,         MaxS},
    '{RowPredict,  clsr_pkg::CmdDraw,   MinS,          32'hFFFF_FFFF},
    '{RowBadRange, clsr_pkg::CmdDraw,   32'd1,         32'd0},
    '{RowPredict,  clsr_pkg::CmdReseed, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{RowPredict,  clsr_pkg::CmdDraw,   32'd0,         32'd1},
    '{RowPredict,  clsr_pkg::CmdDraw,   32'hFFFF_FC18, 32'd1000},
    '{RowPredict,  clsr_pkg::CmdDraw,   32'hAAAA_AAAA, 32'h5555_5555},
    '{RowBadRange, clsr_pkg::CmdDraw,   32'd0,         32'hFFFF_FFFF}
  };

  localparam logic [30:0] SeedCorners [5] = '{
    31'd0, clsr_pkg::ModOne, clsr_pkg::ModTwo, 31'h7FFF_FFFF, clsr_pkg::ModOne - 31'd1
  };

  localparam logic [31:0] BoundCorners [6] = '{
    MinS, MaxS, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'h8000_0001
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [30:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  clsr_pkg::rng_in_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  clsr_pkg::rng_out_t out_item_o;

  // generator mirror
  logic [30:0] seed_reg;
  logic [30:0] gen_a;
  logic [30:0] gen_b;
  logic [30:0] shuffle [clsr_pkg::TableSize];
  logic [30:0] last_out;
  logic        seeded_st;

  clsr_pkg::rng_out_t pending_draws[$];
  clsr_pkg::rng_out_t expected_draw;
  int unsigned        mismatch_count = 0;
  int unsigned        burst_left = 0;
  bit                 hold_off_req = 1'b0;

  combined_lcg_shuffle_rng DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [30:0] lcg_advance(logic [30:0] x, logic [15:0] mul,
                                              logic [30:0] modulus);
    logic [63:0] prod;
    prod = 64'(x) * 64'(mul);
    return 31'(prod % 64'(modulus));
  endfunction

  function automatic void apply_reseed();
    logic [30:0] s;
    int n;
    s = (seed_reg == 31'd0) ? 31'd1 : seed_reg;
    gen_a = s;
    gen_b = s;
    for (n = int'(clsr_pkg::WarmSteps) - 1; n >= 0; n--) begin
      gen_a = lcg_advance(gen_a, clsr_pkg::MulOne, clsr_pkg::ModOne);
      if (n < int'(clsr_pkg::TableSize)) shuffle[n] = gen_a;
    end
    last_out  = shuffle[0];
    seeded_st = 1'b1;
  endfunction

  function automatic clsr_pkg::rng_out_t draw_outcome(clsr_pkg::rng_in_t item);
    clsr_pkg::rng_out_t r;
    int unsigned        slot;
    longint             diff;
    longint             lo;
    longint             hi;
    logic [30:0]        raw;
    logic [63:0]        span;
    logic [63:0]        off;
    r = '0;
    if (!seeded_st) begin
      r.not_seeded = 1'b1;
      return r;
    end
    gen_a = lcg_advance(gen_a, clsr_pkg::MulOne, clsr_pkg::ModOne);
    gen_b = lcg_advance(gen_b, clsr_pkg::MulTwo, clsr_pkg::ModTwo);
    slot = last_out / clsr_pkg::SlotDiv;
    if (slot >= clsr_pkg::TableSize) slot = clsr_pkg::TableSize - 1;
    diff = $signed({33'd0, shuffle[slot]}) - $signed({33'd0, gen_b});
    shuffle[slot] = gen_a;
    if (diff < 1) diff += longint'(clsr_pkg::TopVal);
    raw = diff[30:0];
    last_out = raw;
    r.raw_value = raw;
    r.fraction  = 32'(({33'd0, raw} << 32) / 64'(clsr_pkg::ModOne));
    lo = longint'($signed(item.low_bound));
    hi = longint'($signed(item.high_bound));
    if (hi < lo) begin
      r.bad_range    = 1'b1;
      r.mapped_value = item.low_bound;
    end else begin
      span = 64'(hi - lo + 1);
      off  = (span * 64'(raw)) / 64'(clsr_pkg::ModOne);
      r.mapped_value = 32'(lo + longint'(off));
    end
    return r;
  endfunction

  // Advance the mirror for an accepted transaction and queue what it must produce.
  function automatic void take_item(clsr_pkg::rng_in_t item, row_kind_e kind);
    clsr_pkg::rng_out_t e;
    if (item.cmd == clsr_pkg::CmdReseed) begin
      apply_reseed();
      return;
    end
    e = draw_outcome(item);
    case (kind)
      RowUnseeded: begin
        e = '0;
        e.not_seeded = 1'b1;
      end
      RowBadRange: begin
        e.bad_range    = 1'b1;
        e.mapped_value = item.low_bound;
      end
      RowPoint: begin
        e.bad_range    = 1'b0;
        e.mapped_value = item.low_bound;
      end
      default: ;
    endcase
    pending_draws.push_back(e);
  endfunction

  function automatic clsr_pkg::rng_in_t random_item(bit force_reseed);
    clsr_pkg::rng_in_t it;
    logic [31:0]       lo;
    logic [31:0]       hi;
    it.cmd = (force_reseed || $urandom_range(0, 15) == 0) ? clsr_pkg::CmdReseed
                                                           : clsr_pkg::CmdDraw;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        lo = $urandom();
        hi = $urandom();
      end
      3, 4: begin
        lo = $urandom();
        hi = lo + 32'($urandom_range(0, 1000));
        if ($signed(hi) < $signed(lo)) hi = MaxS;
      end
      5: begin
        lo = $urandom();
        hi = lo;
      end
      6: begin
        lo = BoundCorners[$urandom_range(0, 5)];
        hi = BoundCorners[$urandom_range(0, 5)];
      end
      default: begin
        lo = 32'($urandom_range(0, 200)) - 32'd100;
        hi = lo + 32'($urandom_range(0, 300));
      end
    endcase
    it.low_bound  = lo;
    it.high_bound = hi;
    return it;
  endfunction

  // Offer one transaction in bursts with random gaps; return at the next falling edge.
  task automatic issue(input clsr_pkg::rng_in_t item, input row_kind_e kind);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    take_item(item, kind);
    @(negedge clk_i);
  endtask

  // Drain every pending draw, then give a late reseed time to finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_seed(input logic [30:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    seed_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, out_item_o);
        mismatch_count++;
      end else begin
        expected_draw = pending_draws.pop_front();
        check_field("raw_value", 32'(expected_draw.raw_value), 32'(out_item_o.raw_value));
        check_field("fraction", expected_draw.fraction, out_item_o.fraction);
        check_field("mapped_value", expected_draw.mapped_value, out_item_o.mapped_value);
        check_field("bad_range", 32'(expected_draw.bad_range), 32'(out_item_o.bad_range));
        check_field("not_seeded", 32'(expected_draw.not_seeded), 32'(out_item_o.not_seeded));
      end
    end
  end

  // Output stall pattern: stretches of free flow, light and heavy stalls, toggling.
  initial begin : stall_pattern
    int unsigned span_left;
    int unsigned mode;
    span_left = 0;
    mode = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if (span_left == 0) begin
        mode = $urandom_range(0, 3);
        span_left = $urandom_range(8, 80);
      end
      span_left--;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    clsr_pkg::rng_in_t item;
    int                r;
    int                p;
    int                k;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    seed_reg    = clsr_pkg::SeedReset;
    gen_a       = '0;
    gen_b       = '0;
    last_out    = '0;
    seeded_st   = 1'b0;
    for (r = 0; r < int'(clsr_pkg::TableSize); r++) shuffle[r] = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows, starting from the reset seed
    for (r = 0; r < $size(DirectedRows); r++) begin
      item.cmd        = DirectedRows[r].cmd;
      item.low_bound  = DirectedRows[r].lo;
      item.high_bound = DirectedRows[r].hi;
      issue(item, DirectedRows[r].kind);
    end

    // corner seeds, zero and both moduli among them
    for (p = 0; p < $size(SeedCorners); p++) begin
      settle();
      write_seed(SeedCorners[p]);
      issue(random_item(1'b1), RowPredict);
      for (k = 0; k < 6; k++) begin
        item = random_item(1'b0);
        item.cmd = clsr_pkg::CmdDraw;
        issue(item, RowPredict);
      end
    end

    for (p = 0; p < int'(PhaseCount); p++) begin
      settle();
      if ($urandom_range(0, 3) == 0) write_seed(SeedCorners[$urandom_range(0, 4)]);
      else write_seed(31'($urandom()));
      // hold the output long enough to back the block up
      if (p == 3) hold_off_req = 1'b1;
      issue(random_item(1'b1), RowPredict);
      for (k = 0; k < int'(PhaseItems); k++) issue(random_item(1'b0), RowPredict);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== combined_lcg_shuffle_rng.f =====
+incdir+sv
sv/clsr_pkg.sv
sv/clsr_cdiv.sv
sv/clsr_ctrl.sv
sv/clsr_dpath.sv
sv/combined_lcg_shuffle_rng.sv
tb/sv/testbench.sv
